// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the framed serial transmitter.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/fst_pkg.sv =====
// Package for the framed serial transmitter: item and result types, frame constants.
// No dependencies.
package fst_pkg;

	localparam int unsigned MAX_PAYLOAD = 15;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned POS_W = 5;
	localparam int unsigned PHASE_W = 4;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [PHASE_W-1:0] PHASE_START  = 4'd0;
	localparam logic [PHASE_W-1:0] PHASE_PARITY = 4'd9;
	localparam logic [PHASE_W-1:0] PHASE_STOP   = 4'd10;

	typedef struct packed {
		logic [3:0] command;
		logic [7:0] data_byte;
		logic [1:0] kind;
	} item_t;

	typedef struct packed {
		logic dropped;
		logic busy_res;
		logic tx_line;
	} result_t;

endpackage

// ===== rtl/fst_engine.sv =====
// Frame state of the transmitter: payload store, header, check byte and bit sequencer.
// Depends on fst_pkg. Applies one item per step and presents its result combinationally.
module fst_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  fst_pkg::item_t  item,
	output fst_pkg::result_t result
);
	import fst_pkg::*;

	function automatic logic [3:0] ones_in(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'd0, b[k]};
		end
		return n;
	endfunction

	logic [7:0]         store_q [MAX_PAYLOAD];
	logic [CNT_W-1:0]   count_q, count_n;
	logic [7:0]         header_q, header_n;
	logic [7:0]         check_q, check_n;
	logic [6:0]         pl_ones_q, pl_ones_n;
	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic               sending_q, sending_n;
	logic               line_q, line_n;
	logic               drop;
	logic               wr_en;
	logic [7:0]         cur_byte;
	logic [3:0]         rd_idx;
	logic [7:0]         hdr;

	assign rd_idx = pos_q[3:0] - 4'd1;
	assign hdr    = {count_q, item.command};

	always_comb begin
		if (pos_q == '0) begin
			cur_byte = header_q;
		end else if ({1'b0, pos_q} <= {2'b0, count_q}) begin
			cur_byte = store_q[rd_idx];
		end else begin
			cur_byte = check_q;
		end
	end

	always_comb begin
		count_n   = count_q;
		header_n  = header_q;
		check_n   = check_q;
		pl_ones_n = pl_ones_q;
		phase_n   = phase_q;
		pos_n     = pos_q;
		sending_n = sending_q;
		line_n    = line_q;
		drop      = 1'b0;
		wr_en     = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				if (sending_q) begin
					if (phase_q == PHASE_START) begin
						line_n = 1'b0;
					end else if (phase_q < PHASE_PARITY) begin
						line_n = cur_byte[phase_q[2:0] - 3'd1];
					end else if (phase_q == PHASE_PARITY) begin
						line_n = ^cur_byte;
					end else begin
						line_n = 1'b1;
					end
					if (phase_q == PHASE_STOP) begin
						phase_n = PHASE_START;
						pos_n   = pos_q + 5'd1;
						if (({1'b0, pos_q} + 6'd1) >= ({2'b0, count_q} + 6'd2)) begin
							sending_n = 1'b0;
							pos_n     = '0;
							count_n   = '0;
							pl_ones_n = '0;
						end
					end else begin
						phase_n = phase_q + 4'd1;
					end
				end else begin
					line_n = 1'b1;
				end
			end
			KIND_LOAD: begin
				if (sending_q || ({28'd0, count_q} >= MAX_PAYLOAD)) begin
					drop = 1'b1;
				end else begin
					wr_en     = 1'b1;
					count_n   = count_q + 4'd1;
					pl_ones_n = pl_ones_q + {3'd0, ones_in(item.data_byte)};
				end
			end
			KIND_START: begin
				if (sending_q) begin
					drop = 1'b1;
				end else begin
					header_n  = hdr;
					check_n   = {1'b0, pl_ones_q} + {4'd0, ones_in(hdr)};
					phase_n   = PHASE_START;
					pos_n     = '0;
					sending_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.tx_line  = line_n;
	assign result.busy_res = sending_n;
	assign result.dropped  = drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			header_q  <= '0;
			check_q   <= '0;
			pl_ones_q <= '0;
			phase_q   <= '0;
			pos_q     <= '0;
			sending_q <= 1'b0;
			line_q    <= 1'b1;
		end else if (step) begin
			count_q   <= count_n;
			header_q  <= header_n;
			check_q   <= check_n;
			pl_ones_q <= pl_ones_n;
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			sending_q <= sending_n;
			line_q    <= line_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			store_q[count_q] <= item.data_byte;
		end
	end

endmodule

// ===== rtl/framed_serial_transmitter_top.sv =====
// Top level of the framed serial transmitter: input register, frame engine, result register.
// Depends on fst_pkg, fst_engine and assert_macros.svh.
//
//  channel | dir | tdata                          | tuser
//  s_*     | in  | [7:0] data_byte, [11:8] command | [1:0] kind
//  m_*     | out | [0] tx_line, [1] busy_res, [2] dropped | -
//
// Every item gives one result; one item per cycle sustained while m_tready does not stall.
// The rate is set by the single engine step between input and result register.
// Reset (arst_n low) empties both registers, idles the line high and empties the payload.
// A stall on m_tready holds the result; one more item waits in the input register.
`include "assert_macros.svh"

module framed_serial_transmitter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] data_byte, [11:8] command, rest zero
	input  logic [1:0]  s_tuser,  // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [0] tx_line, [1] busy_res, [2] dropped, rest zero
);
	import fst_pkg::*;

	logic    item_vld_s1;
	item_t   item_s1;
	logic    res_vld_q;
	result_t res_q;
	result_t res;
	logic    advance;

	assign advance  = item_vld_s1 && (!res_vld_q || m_tready);
	assign s_tready = !item_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			if (s_tready) begin
				item_vld_s1 <= s_tvalid;
			end
			if (advance) begin
				res_vld_q <= 1'b1;
			end else if (m_tready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind      <= s_tuser;
			item_s1.data_byte <= s_tdata[7:0];
			item_s1.command   <= s_tdata[11:8];
		end
		if (advance) begin
			res_q <= res;
		end
	end

	fst_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res)
	);

	assign m_tvalid = res_vld_q;
	assign m_tdata  = {5'd0, res_q.dropped, res_q.busy_res, res_q.tx_line};

	`ASSERT_IMP(a_ready_when_empty, !res_vld_q, s_tready)
	`ASSERT_IMP(a_idle_line_high, advance && item_s1.kind == KIND_TICK && !res.busy_res, res.tx_line)
	`ASSERT_IMP(a_tick_never_drops, advance && item_s1.kind == KIND_TICK, !res.dropped)
	`ASSERT_NXT(a_result_follows, advance, res_vld_q)

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for framed_serial_transmitter_top: drives load, start, tick and unused
// items over the stream ports, and checks each line/busy/refused status against a local predictor
// or a directed row's typed status. Depends on fst_pkg and the transmitter RTL.
module tb;
	import fst_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int BIT_TIMES    = 11;
	localparam int N_ITEMS      = 700;
	localparam int PRESSURE_AT  = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;

	typedef enum int {PACE_STEADY, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] dat;
		logic [3:0] cmd;
		int         reps;
		bit         typed;
		result_t    res;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = KIND_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	pace_t   pace = PACE_STEADY;
	logic    hold_req = 1'b0;
	result_t expected_status[$];
	int      errors = 0;
	int      items_in = 0;
	int      checked = 0;
	int      frames_started = 0;
	int      refusals = 0;

	// transmitter state as predicted
	logic [7:0]         pl_bytes [MAX_PAYLOAD];
	logic [CNT_W-1:0]   pl_count = '0;
	logic [7:0]         hdr_byte = '0;
	logic [7:0]         chk_byte = '0;
	logic [PHASE_W-1:0] phase = PHASE_START;
	logic [POS_W-1:0]   pos = '0;
	logic               sending = 1'b0;
	logic               line_lvl = 1'b1;

	// directed sequence; typed rows carry their status, the rest use the predictor
	step_t plan [14] = '{
		'{KIND_TICK,  8'h00, 4'h0, 1,  1'b1, 3'b001},  // idle tick
		'{KIND_NONE,  8'hFF, 4'hF, 1,  1'b1, 3'b001},
		'{KIND_START, 8'h00, 4'hF, 1,  1'b1, 3'b011},  // empty payload
		'{KIND_START, 8'h00, 4'h0, 1,  1'b1, 3'b111},  // start while busy
		'{KIND_LOAD,  8'hFF, 4'h0, 1,  1'b1, 3'b111},  // load while busy
		'{KIND_NONE,  8'h00, 4'h0, 1,  1'b1, 3'b011},
		'{KIND_TICK,  8'h00, 4'h0, 1,  1'b1, 3'b010},  // start bit
		'{KIND_TICK,  8'h00, 4'h0, 20, 1'b0, 3'b000},
		'{KIND_TICK,  8'h00, 4'h0, 1,  1'b1, 3'b001},  // stop bit of check byte, frame done
		'{KIND_LOAD,  8'hFF, 4'h0, 7,  1'b1, 3'b001},
		'{KIND_LOAD,  8'h00, 4'h0, 8,  1'b1, 3'b001},
		'{KIND_LOAD,  8'h5A, 4'h0, 1,  1'b1, 3'b101},  // store full
		'{KIND_START, 8'h00, 4'h0, 1,  1'b1, 3'b011},
		'{KIND_TICK,  8'h00, 4'h0, 1,  1'b1, 3'b010}
	};

	framed_serial_transmitter_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t advance_transmitter(input logic [1:0] kind,
		input logic [7:0] dat, input logic [3:0] cmd);
		logic [7:0] cur;
		int total;
		result_t r;
		r.dropped = 1'b0;
		case (kind)
			KIND_TICK: begin
				if (sending) begin
					if (pos == 0)
						cur = hdr_byte;
					else if (pos <= pl_count)
						cur = pl_bytes[pos - 1];
					else
						cur = chk_byte;
					if (phase == PHASE_START)
						line_lvl = 1'b0;
					else if (phase < PHASE_PARITY)
						line_lvl = cur[phase - 1];
					else if (phase == PHASE_PARITY)
						line_lvl = ^cur;
					else
						line_lvl = 1'b1;
					if (phase == PHASE_STOP) begin
						phase = PHASE_START;
						pos = pos + 1'b1;
						if (pos >= pl_count + 2) begin
							sending = 1'b0;
							pos = '0;
							pl_count = '0;
						end
					end else begin
						phase = phase + 1'b1;
					end
				end else begin
					line_lvl = 1'b1;
				end
			end
			KIND_LOAD: begin
				if (sending || pl_count >= MAX_PAYLOAD) begin
					r.dropped = 1'b1;
				end else begin
					pl_bytes[pl_count] = dat;
					pl_count = pl_count + 1'b1;
				end
			end
			KIND_START: begin
				if (sending) begin
					r.dropped = 1'b1;
				end else begin
					hdr_byte = {pl_count, cmd};
					total = $countones(hdr_byte);
					for (int i = 0; i < pl_count; i++)
						total += $countones(pl_bytes[i]);
					chk_byte = total[7:0];
					phase = PHASE_START;
					pos = '0;
					sending = 1'b1;
					frames_started++;
				end
			end
			default: ;
		endcase
		r.tx_line = line_lvl;
		r.busy_res = sending;
		return r;
	endfunction

	task automatic offer(input logic [1:0] kind, input logic [7:0] dat, input logic [3:0] cmd,
		input bit typed, input result_t typed_res);
		int gap;
		result_t res;
		gap = (pace == PACE_SRC_GAPS) ? 55 : (pace == PACE_BOTH) ? 8 : 0;
		while ($urandom_range(0, 99) < gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, cmd, dat};
		s_tuser <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		res = advance_transmitter(kind, dat, cmd);
		if (res.dropped)
			refusals++;
		expected_status.push_back(typed ? typed_res : res);
		if (kind != KIND_NONE)
			items_in++;
		if (items_in == PRESSURE_AT && kind != KIND_NONE)
			hold_req = 1'b1;
		pace = pace_t'((items_in / 120) % 4);
	endtask

	task automatic compare_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			errors++;
		end
	endtask

	// sink: random stalls, plus one long hold-off so the input backs up
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = (pace == PACE_SINK_STALLS) ? 55 : (pace == PACE_BOTH) ? 8 : 0;
				m_tready <= ($urandom_range(0, 99) >= stall);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[2:0]);
			if (expected_status.size() == 0) begin
				$error("status transfer with none outstanding: %03b", got);
				errors++;
			end else begin
				want = expected_status.pop_front();
				compare_field("tx_line", want.tx_line, got.tx_line);
				compare_field("busy_res", want.busy_res, got.busy_res);
				compare_field("dropped", want.dropped, got.dropped);
				checked++;
			end
		end
	end

	initial begin
		int owed;
		int len;
		int pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			repeat (plan[i].reps)
				offer(plan[i].kind, plan[i].dat, plan[i].cmd, plan[i].typed, plan[i].res);

		// the full-store frame is still on the line: 17 bytes, one tick already given
		owed = (MAX_PAYLOAD + 2) * BIT_TIMES - 1;

		while (items_in < N_ITEMS || owed > 0) begin
			while (owed > 0) begin
				if ($urandom_range(0, 9) == 0) begin
					offer(2'($urandom_range(1, 3)), 8'($urandom), 4'($urandom), 1'b0, '0);
				end else begin
					offer(KIND_TICK, 8'($urandom), 4'($urandom), 1'b0, '0);
					owed--;
				end
			end
			if (items_in < N_ITEMS) begin
				repeat ($urandom_range(0, 2))
					offer(KIND_TICK, 8'($urandom), 4'($urandom), 1'b0, '0);
				pick = $urandom_range(0, 9);
				if (pick < 7)
					len = $urandom_range(0, 4);
				else if (pick < 9)
					len = $urandom_range(5, 14);
				else
					len = $urandom_range(15, 18);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(0, 7) == 0)
						offer($urandom_range(0, 1) ? KIND_NONE : KIND_TICK,
							8'($urandom), 4'($urandom), 1'b0, '0);
					offer(KIND_LOAD, 8'($urandom), 4'($urandom), 1'b0, '0);
				end
				offer(KIND_START, 8'($urandom), 4'($urandom), 1'b0, '0);
				owed = ((len > MAX_PAYLOAD ? MAX_PAYLOAD : len) + 2) * BIT_TIMES;
			end
		end

		s_tvalid <= 1'b0;
		pace = PACE_STEADY;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items, %0d frames started, %0d refused loads/starts, %0d statuses checked",
			items_in, frames_started, refusals, checked);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("tb failed");
		$finish;
	end

endmodule
